@@ sv/obc_pkg.sv @@
`timescale 1ns / 1ps
package obc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TRIG_W = 34;
  localparam int ANG_W = 33;
  localparam int DIM_W = 16;
  localparam int PROD_W = DIM_W + 1 + TRIG_W;
  localparam int TERM_W = PROD_W - 30;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_OVERHANG = 3'd0,
    REG_WIDTH    = 3'd1,
    REG_LENGTH   = 3'd2,
    REG_XLO      = 3'd3,
    REG_XHI      = 3'd4,
    REG_YLO      = 3'd5,
    REG_YHI      = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                     vld;
    logic [1:0]               quad;
    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] sy;
    logic signed [ANG_W-1:0]  z;
  } cordic_t;

  // Arc tangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [ANG_W-1:0] atan_turn(input logic [3:0] idx);
    logic signed [ANG_W-1:0] a;
    unique case (idx)
      4'd0:  a = 33'sd536870912;
      4'd1:  a = 33'sd316933406;
      4'd2:  a = 33'sd167458907;
      4'd3:  a = 33'sd85004756;
      4'd4:  a = 33'sd42667331;
      4'd5:  a = 33'sd21354465;
      4'd6:  a = 33'sd10679838;
      4'd7:  a = 33'sd5340245;
      4'd8:  a = 33'sd2670163;
      4'd9:  a = 33'sd1335087;
      4'd10: a = 33'sd667544;
      4'd11: a = 33'sd333772;
      4'd12: a = 33'sd166886;
      4'd13: a = 33'sd83443;
      4'd14: a = 33'sd41722;
      default: a = 33'sd20861;
    endcase
    return a;
  endfunction

endpackage

@@ sv/obc_cordic_stage.sv @@
`timescale 1ns / 1ps
module obc_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  obc_pkg::cordic_t st_in,
  output obc_pkg::cordic_t st_out
);

  obc_pkg::cordic_t st_r;
  obc_pkg::cordic_t st_nxt;

  always_comb begin
    st_nxt = st_in;
    if (!st_in.z[obc_pkg::ANG_W-1]) begin
      st_nxt.cx = st_in.cx - (st_in.sy >>> STAGE);
      st_nxt.sy = st_in.sy + (st_in.cx >>> STAGE);
      st_nxt.z  = st_in.z - obc_pkg::atan_turn(4'(STAGE));
    end else begin
      st_nxt.cx = st_in.cx + (st_in.sy >>> STAGE);
      st_nxt.sy = st_in.sy - (st_in.cx >>> STAGE);
      st_nxt.z  = st_in.z + obc_pkg::atan_turn(4'(STAGE));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule

@@ sv/obc_corner.sv @@
`timescale 1ns / 1ps
module obc_corner #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  obc_pkg::cordic_t             st_in,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic [obc_pkg::DIM_W-1:0]    overhang,
  input  logic [obc_pkg::DIM_W-1:0]    width,
  input  logic [obc_pkg::DIM_W-1:0]    length,
  input  logic signed [COORD_BITS-1:0] xlo,
  input  logic signed [COORD_BITS-1:0] xhi,
  input  logic signed [COORD_BITS-1:0] ylo,
  input  logic signed [COORD_BITS-1:0] yhi,
  output logic                         res_vld,
  output logic                         res_inside
);

  localparam int TW = obc_pkg::TERM_W;
  localparam int PW = obc_pkg::PROD_W;
  localparam int CW = COORD_BITS + 4;
  localparam logic signed [PW-1:0] RND30 = PW'(1) <<< 29;
  localparam logic signed [PW-1:0] RND31 = PW'(1) <<< 30;

  // Stage 1: quadrant mapping.
  logic                                v1_r;
  logic signed [obc_pkg::TRIG_W-1:0]   c1_r, s1_r;
  logic signed [COORD_BITS-1:0]        px1_r, py1_r;
  logic signed [obc_pkg::TRIG_W-1:0]   c1_nxt, s1_nxt;

  always_comb begin
    unique case (st_in.quad)
      2'd0: begin c1_nxt = st_in.cx;  s1_nxt = st_in.sy;  end
      2'd1: begin c1_nxt = -st_in.sy; s1_nxt = st_in.cx;  end
      2'd2: begin c1_nxt = -st_in.cx; s1_nxt = -st_in.sy; end
      default: begin c1_nxt = st_in.sy; s1_nxt = -st_in.cx; end
    endcase
  end

  // Stage 2: products.
  logic                         v2_r;
  logic signed [PW-1:0]         pdc_r, pds_r, pwc_r, pws_r, plc_r, pls_r;
  logic signed [COORD_BITS-1:0] px2_r, py2_r;

  // Stage 3: rounded terms.
  logic                         v3_r;
  logic signed [TW-1:0]         dc_r, ds_r, wc2_r, ws2_r, wc_r, ws_r, lc_r, ls_r;
  logic signed [COORD_BITS-1:0] px3_r, py3_r;
  logic signed [PW-1:0]         rdc, rds, rwc, rws, rwc2, rws2, rlc, rls;

  assign rdc  = pdc_r + RND30;
  assign rds  = pds_r + RND30;
  assign rwc  = pwc_r + RND30;
  assign rws  = pws_r + RND30;
  assign rwc2 = pwc_r + RND31;
  assign rws2 = pws_r + RND31;
  assign rlc  = plc_r + RND30;
  assign rls  = pls_r + RND30;

  // Stage 4: corner A; stage 5: corners B, C, D.
  logic                 v4_r, v5_r;
  logic signed [CW-1:0] ax_r, ay_r, wc4_r, ws4_r, lc4_r, ls4_r;
  logic signed [CW-1:0] ax5_r, ay5_r, bx_r, by_r, cx_r, cy_r, dx_r, dy_r;
  logic signed [CW-1:0] ax_nxt, ay_nxt;

  assign ax_nxt = CW'(px3_r) - CW'(dc_r) - CW'(ws2_r);
  assign ay_nxt = CW'(py3_r) - CW'(ds_r) + CW'(wc2_r);

  // Stage 6: limit compare.
  logic res_vld_r, res_inside_r;
  logic inside_nxt;

  function automatic logic pt_ok(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                                 input logic signed [CW-1:0] xl, input logic signed [CW-1:0] xh,
                                 input logic signed [CW-1:0] yl, input logic signed [CW-1:0] yh);
    return (x > xl) && (x < xh) && (y > yl) && (y < yh);
  endfunction

  always_comb begin
    inside_nxt = pt_ok(ax5_r, ay5_r, CW'(xlo), CW'(xhi), CW'(ylo), CW'(yhi))
              && pt_ok(bx_r, by_r, CW'(xlo), CW'(xhi), CW'(ylo), CW'(yhi))
              && pt_ok(cx_r, cy_r, CW'(xlo), CW'(xhi), CW'(ylo), CW'(yhi))
              && pt_ok(dx_r, dy_r, CW'(xlo), CW'(xhi), CW'(ylo), CW'(yhi));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      v1_r      <= st_in.vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      res_vld_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_r  <= c1_nxt;
    s1_r  <= s1_nxt;
    px1_r <= px;
    py1_r <= py;

    pdc_r <= $signed({1'b0, overhang}) * c1_r;
    pds_r <= $signed({1'b0, overhang}) * s1_r;
    pwc_r <= $signed({1'b0, width}) * c1_r;
    pws_r <= $signed({1'b0, width}) * s1_r;
    plc_r <= $signed({1'b0, length}) * c1_r;
    pls_r <= $signed({1'b0, length}) * s1_r;
    px2_r <= px1_r;
    py2_r <= py1_r;

    dc_r  <= rdc[PW-1:30];
    ds_r  <= rds[PW-1:30];
    wc_r  <= rwc[PW-1:30];
    ws_r  <= rws[PW-1:30];
    lc_r  <= rlc[PW-1:30];
    ls_r  <= rls[PW-1:30];
    wc2_r <= TW'($signed(rwc2[PW-1:31]));
    ws2_r <= TW'($signed(rws2[PW-1:31]));
    px3_r <= px2_r;
    py3_r <= py2_r;

    ax_r  <= ax_nxt;
    ay_r  <= ay_nxt;
    wc4_r <= CW'(wc_r);
    ws4_r <= CW'(ws_r);
    lc4_r <= CW'(lc_r);
    ls4_r <= CW'(ls_r);

    ax5_r <= ax_r;
    ay5_r <= ay_r;
    bx_r  <= ax_r + ws4_r;
    by_r  <= ay_r - wc4_r;
    cx_r  <= ax_r + ws4_r + lc4_r;
    cy_r  <= ay_r - wc4_r + ls4_r;
    dx_r  <= ax_r + lc4_r;
    dy_r  <= ay_r + ls4_r;

    res_inside_r <= inside_nxt;
  end

  assign res_vld    = res_vld_r;
  assign res_inside = res_inside_r;

endmodule

@@ sv/oriented_box_bounds_check.sv @@
`timescale 1ns / 1ps
// Throughput: one request per clock cycle; busy is held low, so start is never refused.
// The depth is set by an input register, the 16-step CORDIC with one rotation per stage,
// and six stages for quadrant mapping, products, rounding, corner sums and limit compare.
// Reset (rst_n, synchronous, active low) empties the pipeline and restores register defaults.
module oriented_box_bounds_check #(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_BITS-1:0]     in_pos_x,
  input  logic signed [COORD_BITS-1:0]     in_pos_y,
  input  logic [ANGLE_BITS-1:0]            in_heading,
  output logic                             out_valid,
  output logic                             out_inside_res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [((COORD_BITS > 32) ? 6 : 5)-1:0] paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                             pready
);

  localparam int DW = (COORD_BITS > 32) ? 64 : 32;
  localparam int AW = (COORD_BITS > 32) ? 6 : 5;
  localparam int IDX_LSB = (COORD_BITS > 32) ? 3 : 2;
  localparam int STEPS = obc_pkg::CORDIC_STEPS;
  localparam int DIM_W = obc_pkg::DIM_W;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase of the APB
  // transfer; the register index is the word address. Unused indexes are ignored.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]            overhang_r, width_r, length_r;
  logic signed [COORD_BITS-1:0] xlo_r, xhi_r, ylo_r, yhi_r;
  obc_pkg::reg_idx_t            reg_idx;
  logic                         cfg_wr;

  assign reg_idx = obc_pkg::reg_idx_t'(paddr[AW-1:IDX_LSB]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overhang_r <= DIM_W'(256);
      width_r    <= DIM_W'(512);
      length_r   <= DIM_W'(1024);
      xlo_r      <= '0;
      xhi_r      <= COORD_MAX;
      ylo_r      <= '0;
      yhi_r      <= COORD_MAX;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        obc_pkg::REG_OVERHANG: overhang_r <= pwdata[DIM_W-1:0];
        obc_pkg::REG_WIDTH:    width_r    <= pwdata[DIM_W-1:0];
        obc_pkg::REG_LENGTH:   length_r   <= pwdata[DIM_W-1:0];
        obc_pkg::REG_XLO:      xlo_r      <= pwdata[COORD_BITS-1:0];
        obc_pkg::REG_XHI:      xhi_r      <= pwdata[COORD_BITS-1:0];
        obc_pkg::REG_YLO:      ylo_r      <= pwdata[COORD_BITS-1:0];
        obc_pkg::REG_YHI:      yhi_r      <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Limits read back sign-extended to the bus width.
  always_comb begin
    unique case (reg_idx)
      obc_pkg::REG_OVERHANG: prdata = DW'(overhang_r);
      obc_pkg::REG_WIDTH:    prdata = DW'(width_r);
      obc_pkg::REG_LENGTH:   prdata = DW'(length_r);
      obc_pkg::REG_XLO:      prdata = DW'(xlo_r);
      obc_pkg::REG_XHI:      prdata = DW'(xhi_r);
      obc_pkg::REG_YLO:      prdata = DW'(ylo_r);
      obc_pkg::REG_YHI:      prdata = DW'(yhi_r);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input stage. The heading is scaled to a 32-bit fraction of a turn: the top
  // two bits pick the quadrant and the remaining 30 bits seed the CORDIC angle.
  // ---------------------------------------------------------------------------
  logic                 in_acc;
  logic [31:0]          turn;
  obc_pkg::cordic_t     st_in_r;
  obc_pkg::cordic_t     st_in_nxt;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;
  assign turn   = {in_heading, {(32-ANGLE_BITS){1'b0}}};

  always_comb begin
    st_in_nxt.vld  = in_acc;
    st_in_nxt.quad = turn[31:30];
    st_in_nxt.cx   = obc_pkg::CORDIC_GAIN;
    st_in_nxt.sy   = '0;
    st_in_nxt.z    = {3'b000, turn[29:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_in_r.vld <= 1'b0;
    end else begin
      st_in_r <= st_in_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC rotation chain, one micro-rotation per stage. The position travels
  // alongside in a matching delay line.
  // ---------------------------------------------------------------------------
  obc_pkg::cordic_t             st_chain [0:STEPS];
  logic signed [COORD_BITS-1:0] px_r [0:STEPS];
  logic signed [COORD_BITS-1:0] py_r [0:STEPS];

  assign st_chain[0] = st_in_r;

  always_ff @(posedge clk) begin
    px_r[0] <= in_pos_x;
    py_r[0] <= in_pos_y;
    for (int i = 1; i <= STEPS; i++) begin
      px_r[i] <= px_r[i-1];
      py_r[i] <= py_r[i-1];
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_cordic
    obc_cordic_stage #(
      .STAGE(g)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .st_in (st_chain[g]),
      .st_out(st_chain[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Corner placement and the strict inside test against all four limits.
  // Crossed limits simply make every corner fail the inside test.
  // ---------------------------------------------------------------------------
  obc_corner #(
    .COORD_BITS(COORD_BITS)
  ) u_corner (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_in     (st_chain[STEPS]),
    .px        (px_r[STEPS]),
    .py        (py_r[STEPS]),
    .overhang  (overhang_r),
    .width     (width_r),
    .length    (length_r),
    .xlo       (xlo_r),
    .xhi       (xhi_r),
    .ylo       (ylo_r),
    .yhi       (yhi_r),
    .res_vld   (out_valid),
    .res_inside(out_inside_res)
  );

`ifndef ASSERT_OFF
  // Every result strobe traces back to exactly one accepted request.
  a_strobe_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, 23))
    else $error("result strobe without a matching request");

  // Every accepted request yields its result strobe.
  a_request_gives_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##23 out_valid)
    else $error("request lost in the pipeline");

  // A valid CORDIC output stage traces back to a valid entry stage, one register per micro-rotation.
  a_cordic_depth: assert property (@(posedge clk) disable iff (!rst_n)
    st_chain[STEPS].vld |-> $past(st_chain[0].vld, 16))
    else $error("CORDIC valid out of step");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;
  localparam int PIPE_DEPTH = 23;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = 24'sh800000;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [COORD_BITS-1:0] in_pos_x;
  logic signed [COORD_BITS-1:0] in_pos_y;
  logic [ANGLE_BITS-1:0] in_heading;
  logic out_valid;
  logic out_inside_res;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  oriented_box_bounds_check #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_heading(in_heading),
    .out_valid(out_valid),
    .out_inside_res(out_inside_res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Shadow copy of the register file, updated whenever a write completes.
  logic [15:0] shadow_overhang;
  logic [15:0] shadow_width;
  logic [15:0] shadow_length;
  longint shadow_xlo;
  longint shadow_xhi;
  longint shadow_ylo;
  longint shadow_yhi;

  // Expected inside flags, oldest first, one per accepted request.
  bit inside_queue[$];
  int mismatch_count = 0;
  int cycle_count = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Rounded product of a dimension and a trig value, shifted down by s bits.
  // The shift is arithmetic, so rounding is half toward plus infinity.
  function automatic longint scale_term(logic [15:0] dim, longint trig, int s);
    longint p;
    p = longint'(dim) * trig;
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic bit corner_inside(longint x, longint y);
    return x > shadow_xlo && x < shadow_xhi && y > shadow_ylo && y < shadow_yhi;
  endfunction

  // Computes whether all four corners of the vehicle box land strictly
  // within the workspace for the given pose and the current registers.
  function automatic bit predict_inside(logic signed [COORD_BITS-1:0] px,
                                        logic signed [COORD_BITS-1:0] py,
                                        logic [ANGLE_BITS-1:0] hd);
    logic [31:0] turn;
    logic [1:0] quad;
    longint z, cx, sy, dx, dy, c, s;
    longint dc, ds, wc2, ws2, wc, ws, lc, ls, x, y;
    bit ok;
    turn = {hd, 16'b0};
    quad = turn[31:30];
    z = longint'({2'b00, turn[29:0]});
    cx = 652032874;
    sy = 0;
    // Rotate toward the residual angle; one micro-rotation per step.
    for (int i = 0; i < obc_pkg::CORDIC_STEPS; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        sy = sy + dy;
        z = z - longint'(obc_pkg::atan_turn(i[3:0]));
      end else begin
        cx = cx + dx;
        sy = sy - dy;
        z = z + longint'(obc_pkg::atan_turn(i[3:0]));
      end
    end
    // Fold the first-quadrant result back into the heading's quadrant.
    case (quad)
      2'd0: begin c = cx; s = sy; end
      2'd1: begin c = -sy; s = cx; end
      2'd2: begin c = -cx; s = -sy; end
      default: begin c = sy; s = -cx; end
    endcase
    dc = scale_term(shadow_overhang, c, 30);
    ds = scale_term(shadow_overhang, s, 30);
    wc2 = scale_term(shadow_width, c, 31);
    ws2 = scale_term(shadow_width, s, 31);
    wc = scale_term(shadow_width, c, 30);
    ws = scale_term(shadow_width, s, 30);
    lc = scale_term(shadow_length, c, 30);
    ls = scale_term(shadow_length, s, 30);
    // Walk the corners: rear left, rear right, front right, front left.
    x = longint'(px) - dc - ws2;
    y = longint'(py) - ds + wc2;
    ok = corner_inside(x, y);
    x = x + ws;
    y = y - wc;
    ok = ok && corner_inside(x, y);
    x = x + lc;
    y = y + ls;
    ok = ok && corner_inside(x, y);
    x = x - ws;
    y = y + wc;
    ok = ok && corner_inside(x, y);
    return ok;
  endfunction

  // Result checker: every strobe must match the oldest pending expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (inside_queue.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) begin
          $display("Unexpected result strobe: inside_res=%0b", out_inside_res);
        end
      end else begin
        if (out_inside_res !== inside_queue[0]) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("Inside mismatch: expected %0b, actual %0b",
                     inside_queue[0], out_inside_res);
          end
        end
        void'(inside_queue.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Register write through the APB-style port: setup cycle, then access cycle.
  task automatic write_reg(obc_pkg::reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      obc_pkg::REG_OVERHANG: shadow_overhang = value[15:0];
      obc_pkg::REG_WIDTH: shadow_width = value[15:0];
      obc_pkg::REG_LENGTH: shadow_length = value[15:0];
      obc_pkg::REG_XLO: shadow_xlo = longint'($signed(value[COORD_BITS-1:0]));
      obc_pkg::REG_XHI: shadow_xhi = longint'($signed(value[COORD_BITS-1:0]));
      obc_pkg::REG_YLO: shadow_ylo = longint'($signed(value[COORD_BITS-1:0]));
      obc_pkg::REG_YHI: shadow_yhi = longint'($signed(value[COORD_BITS-1:0]));
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] oh, logic [15:0] w, logic [15:0] l,
                           int xlo, int xhi, int ylo, int yhi);
    write_reg(obc_pkg::REG_OVERHANG, {16'b0, oh});
    write_reg(obc_pkg::REG_WIDTH, {16'b0, w});
    write_reg(obc_pkg::REG_LENGTH, {16'b0, l});
    write_reg(obc_pkg::REG_XLO, xlo);
    write_reg(obc_pkg::REG_XHI, xhi);
    write_reg(obc_pkg::REG_YLO, ylo);
    write_reg(obc_pkg::REG_YHI, yhi);
  endtask

  // Presents one pose request and holds it until the block takes it.
  // start stays high on return so back-to-back requests form a burst.
  task automatic send_pose(logic signed [COORD_BITS-1:0] px,
                           logic signed [COORD_BITS-1:0] py,
                           logic [ANGLE_BITS-1:0] hd);
    bit taken;
    start <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_heading <= hd;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    inside_queue = {inside_queue, predict_inside(px, py, hd)};
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Lets the pipeline drain before registers are touched again.
  task automatic drain;
    pause_sender(1);
    while (inside_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  function automatic logic signed [COORD_BITS-1:0] rand_coord(int span);
    if (span == 0) begin
      return COORD_BITS'($urandom);
    end
    return COORD_BITS'($signed($urandom_range(2 * span)) - span);
  endfunction

  // Random poses in bursts with gaps; most stay near the workspace so both
  // answers are common, a few use the full coordinate range.
  task automatic run_random(int count, int span);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        if ($urandom_range(9) == 0) begin
          send_pose(rand_coord(0), rand_coord(0), ANGLE_BITS'($urandom));
        end else begin
          send_pose(rand_coord(span), rand_coord(span), ANGLE_BITS'($urandom));
        end
        sent++;
      end
      if ($urandom_range(3) != 0) begin
        pause_sender($urandom_range(1, 8));
      end
    end
    drain();
  endtask

  // Reset defaults, field extremes and all four quadrants.
  task automatic test_defaults;
    send_pose(24'sd2560, 24'sd2560, 16'd0);
    send_pose(24'sd2560, 24'sd2560, 16'd16384);
    send_pose(24'sd2560, 24'sd2560, 16'd32768);
    send_pose(24'sd2560, 24'sd2560, 16'd49152);
    send_pose(24'sd2560, 24'sd2560, 16'hFFFF);
    send_pose(24'sd300, 24'sd300, 16'd8192);
    send_pose(COORD_MIN, COORD_MIN, 16'd0);
    send_pose(COORD_MAX, COORD_MAX, 16'hFFFF);
    send_pose(COORD_MAX, 24'sd5000, 16'd24576);
    send_pose(24'sd0, 24'sd0, 16'd40960);
    drain();
  endtask

  // A low limit at or above its high limit can never hold a corner.
  task automatic test_crossed_limits;
    write_all(16'd256, 16'd512, 16'd1024, 1000, 1000, -100000, 100000);
    send_pose(24'sd1000, 24'sd0, 16'd0);
    send_pose(24'sd1000, 24'sd0, 16'd16384);
    drain();
    write_all(16'd256, 16'd512, 16'd1024, -100000, 100000, 50000, -50000);
    send_pose(24'sd0, 24'sd0, 16'd0);
    send_pose(24'sd0, 24'sd0, 16'd12345);
    drain();
  endtask

  // Zero dimensions collapse all corners onto the reference point.
  task automatic test_zero_dims;
    write_all(16'd0, 16'd0, 16'd0, -10, 10, -10, 10);
    send_pose(24'sd0, 24'sd0, 16'd4321);
    send_pose(24'sd9, -24'sd9, 16'd0);
    send_pose(24'sd10, 24'sd0, 16'd0);
    send_pose(-24'sd10, 24'sd0, 16'd49152);
    drain();
  endtask

  // A write to the unused address must leave every register alone.
  task automatic test_unused_register;
    write_all(16'd300, 16'd400, 16'd900, -20000, 20000, -20000, 20000);
    write_reg(obc_pkg::REG_NONE, 32'hFFFF_FFFF);
    send_pose(24'sd0, 24'sd0, 16'd0);
    send_pose(24'sd19000, 24'sd0, 16'd0);
    send_pose(24'sd0, 24'sd0, 16'd30000);
    drain();
  endtask

  // Random poses under a series of register settings, extremes included.
  task automatic test_random_settings;
    write_all(16'd256, 16'd512, 16'd1024, -20000, 20000, -20000, 20000);
    run_random(350, 25000);
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, int'(COORD_MIN), int'(COORD_MAX),
              int'(COORD_MIN), int'(COORD_MAX));
    run_random(250, 8000000);
    write_all(16'd0, 16'd0, 16'd0, -500, 500, -500, 500);
    run_random(200, 700);
    for (int k = 0; k < 4; k++) begin
      write_all(16'($urandom), 16'($urandom_range(4000)), 16'($urandom_range(8000)),
                -int'($urandom_range(40000)), int'($urandom_range(40000)),
                -int'($urandom_range(40000)), int'($urandom_range(40000)));
      run_random(210, 45000);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_heading = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    shadow_overhang = 16'd256;
    shadow_width = 16'd512;
    shadow_length = 16'd1024;
    shadow_xlo = 0;
    shadow_xhi = 8388607;
    shadow_ylo = 0;
    shadow_yhi = 8388607;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_crossed_limits();
    test_zero_dims();
    test_unused_register();
    test_random_settings();

    if (mismatch_count == 0 && inside_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
